### rtl/core/dsl_pkg.sv
// ----------------------------------------------------------------------------
// dsl_pkg
// Shared types, codes and sizes of the discrete sampler lookup table.
// ----------------------------------------------------------------------------
package dsl_pkg;

  localparam int TABLE_DEPTH  = 10000;
  localparam int MAX_OUTCOMES = 256;
  localparam int MASS_BITS    = 16;
  localparam int RADIX        = 10;

  localparam int DIGITS_W  = 3;
  localparam int OPCODE_W  = 2;
  localparam int MASS_W    = 16;
  localparam int RND_BITS  = 32;
  localparam int OUTCOME_W = 9;
  localparam int STATUS_W  = 2;
  localparam int FILL_W    = 14;

  localparam int SCALE_W = $clog2(TABLE_DEPTH + 1);
  localparam int ADDR_W  = $clog2(TABLE_DEPTH);
  localparam int CNT_W   = $clog2(MAX_OUTCOMES + 1);
  localparam int PROD_W  = MASS_BITS + SCALE_W;

  // Remainder unit: this many dividend bits are retired per cycle
  localparam int MOD_BITS_PER_CYCLE = 4;
  localparam int MOD_CYCLES         = RND_BITS / MOD_BITS_PER_CYCLE;
  localparam int MOD_CNT_W          = $clog2(MOD_CYCLES);

  // Command queue between front and back; depth is a power of two
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [OPCODE_W-1:0] OP_START  = 2'd0;
  localparam logic [OPCODE_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OPCODE_W-1:0] OP_FINISH = 2'd2;
  localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_READY = 2'd1;
  localparam logic [STATUS_W-1:0] ST_CLIPPED   = 2'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_MANY  = 2'd3;

  localparam logic [DIGITS_W-1:0] DIGITS_RESET = 3'd4;

  typedef struct packed {
    logic [OPCODE_W-1:0] opcode;
    logic [MASS_W-1:0]   mass_fraction;
    logic [RND_BITS-1:0] random_word;
  } item_t;

  typedef struct packed {
    logic [OUTCOME_W-1:0] outcome;
    logic [STATUS_W-1:0]  status;
    logic [FILL_W-1:0]    fill_level;
  } result_t;

  // Classified command handed from front to back
  typedef struct packed {
    logic [OPCODE_W-1:0] op;
    logic [SCALE_W-1:0]  count;
    logic [RND_BITS-1:0] random_word;
  } cmd_t;

  localparam int SCALE_1 = RADIX;
  localparam int SCALE_2 = SCALE_1 * RADIX;
  localparam int SCALE_3 = SCALE_2 * RADIX;
  localparam int SCALE_4 = SCALE_3 * RADIX;

  // Table size for a digit count: zero counts as one, above four as four
  function automatic logic [SCALE_W-1:0] scale_of(input logic [DIGITS_W-1:0] digits);
    logic [SCALE_W-1:0] s;
    unique case (digits) inside
      3'd0, 3'd1: s = SCALE_W'((SCALE_1 < TABLE_DEPTH) ? SCALE_1 : TABLE_DEPTH);
      3'd2:       s = SCALE_W'((SCALE_2 < TABLE_DEPTH) ? SCALE_2 : TABLE_DEPTH);
      3'd3:       s = SCALE_W'((SCALE_3 < TABLE_DEPTH) ? SCALE_3 : TABLE_DEPTH);
      default:    s = SCALE_W'((SCALE_4 < TABLE_DEPTH) ? SCALE_4 : TABLE_DEPTH);
    endcase
    return s;
  endfunction

endpackage

### rtl/core/dsl_front.sv
// ----------------------------------------------------------------------------
// dsl_front
// Accepts input transactions, scales the mass into an entry count and
// registers the classified command for the queue.
// ----------------------------------------------------------------------------
module dsl_front import dsl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_ready,
  input  item_t              item,
  input  logic [SCALE_W-1:0] scale,
  output logic               cmd_valid,
  input  logic               cmd_ready,
  output cmd_t               cmd
);

  logic              stage_valid;
  cmd_t              stage;
  logic [PROD_W-1:0] product;

  assign product    = PROD_W'(item.mass_fraction[MASS_BITS-1:0]) * PROD_W'(scale);
  assign item_ready = !stage_valid || cmd_ready;
  assign cmd_valid  = stage_valid;
  assign cmd        = stage;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && item_ready) begin
      stage.op          <= item.opcode;
      stage.count       <= product[PROD_W-1:MASS_BITS];
      stage.random_word <= item.random_word;
    end
  end

endmodule

### rtl/core/dsl_queue.sv
// ----------------------------------------------------------------------------
// dsl_queue
// Short command queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module dsl_queue import dsl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  cmd_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output cmd_t pop_data
);

  cmd_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push_fire;
  logic              pop_fire;

  assign push_ready = count != QCNT_W'(QUEUE_DEPTH);
  assign pop_valid  = count != '0;
  assign pop_data   = entries[rd_ptr];
  assign push_fire  = push_valid && push_ready;
  assign pop_fire   = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push_fire) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push_fire) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop_fire) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({push_fire, pop_fire})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### rtl/core/dsl_back.sv
// ----------------------------------------------------------------------------
// dsl_back
// Executes commands: fills the outcome table one entry per cycle, reduces
// sample words modulo the table size and reads the table.
// ----------------------------------------------------------------------------
module dsl_back import dsl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               restart,
  input  logic [SCALE_W-1:0] scale,
  input  logic               cmd_valid,
  output logic               cmd_ready,
  input  cmd_t               cmd,
  output logic               result_valid,
  input  logic               result_ready,
  output result_t            result
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_FILL = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_READ = 3'd3;
  localparam logic [2:0] S_RESP = 3'd4;

  logic [2:0]           state;
  logic [SCALE_W-1:0]   fill_pointer;
  logic [CNT_W-1:0]     outcome_counter;
  logic                 table_ready;
  logic [SCALE_W-1:0]   fill_end;
  logic [OUTCOME_W-1:0] fill_value;
  logic                 set_ready;
  logic [SCALE_W-1:0]   rem;
  logic [SCALE_W-1:0]   rem_next;
  logic [RND_BITS-1:0]  shift;
  logic [MOD_CNT_W-1:0] mod_cnt;
  logic [OUTCOME_W-1:0] res_outcome;
  logic [STATUS_W-1:0]  res_status;
  logic                 res_from_mem;
  logic [OUTCOME_W-1:0] outcome_table [TABLE_DEPTH];
  logic [OUTCOME_W-1:0] rd_data;
  logic [SCALE_W:0]     load_end;
  logic                 load_clip;
  logic [SCALE_W-1:0]   load_stop;
  logic [SCALE_W-1:0]   fill_pointer_inc;

  assign cmd_ready        = state == S_IDLE;
  assign load_end         = {1'b0, fill_pointer} + {1'b0, cmd.count};
  assign load_clip        = load_end > {1'b0, scale};
  assign load_stop        = load_clip ? scale : load_end[SCALE_W-1:0];
  assign fill_pointer_inc = fill_pointer + 1'b1;

  // Restoring remainder steps, most significant dividend bit first
  always_comb begin
    logic [SCALE_W:0] t;
    rem_next = rem;
    for (int i = 0; i < MOD_BITS_PER_CYCLE; i++) begin
      t = {rem_next, shift[RND_BITS-1-i]};
      if (t >= {1'b0, scale}) begin
        t = t - {1'b0, scale};
      end
      rem_next = t[SCALE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FILL) begin
      outcome_table[fill_pointer[ADDR_W-1:0]] <= fill_value;
    end
    if (state == S_READ) begin
      rd_data <= outcome_table[rem[ADDR_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      fill_pointer    <= '0;
      outcome_counter <= '0;
      table_ready     <= 1'b0;
      result_valid    <= 1'b0;
    end else begin
      // drop the accepted result unless the next one loads now
      if (result_ready && state != S_RESP) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_valid) begin
            res_outcome  <= '0;
            res_status   <= ST_OK;
            res_from_mem <= 1'b0;
            state        <= S_RESP;
            unique case (cmd.op)
              OP_START: begin
                fill_pointer    <= '0;
                outcome_counter <= '0;
                table_ready     <= 1'b0;
              end
              OP_LOAD: begin
                if (!table_ready) begin
                  if (outcome_counter >= CNT_W'(MAX_OUTCOMES)) begin
                    res_status <= ST_TOO_MANY;
                  end else begin
                    res_status      <= load_clip ? ST_CLIPPED : ST_OK;
                    fill_value      <= OUTCOME_W'(outcome_counter);
                    outcome_counter <= outcome_counter + 1'b1;
                    fill_end        <= load_stop;
                    set_ready       <= 1'b0;
                    if (load_stop != fill_pointer) begin
                      state <= S_FILL;
                    end
                  end
                end
              end
              OP_FINISH: begin
                if (!table_ready) begin
                  fill_value <= OUTCOME_W'(outcome_counter);
                  fill_end   <= scale;
                  set_ready  <= 1'b1;
                  if (fill_pointer != scale) begin
                    state <= S_FILL;
                  end else begin
                    table_ready <= 1'b1;
                  end
                end
              end
              default: begin
                if (!table_ready) begin
                  res_status <= ST_NOT_READY;
                end else begin
                  res_from_mem <= 1'b1;
                  shift        <= cmd.random_word;
                  rem          <= '0;
                  mod_cnt      <= '0;
                  state        <= S_MOD;
                end
              end
            endcase
          end
        end
        S_FILL: begin
          fill_pointer <= fill_pointer_inc;
          if (fill_pointer_inc == fill_end) begin
            if (set_ready) begin
              table_ready <= 1'b1;
            end
            state <= S_RESP;
          end
        end
        S_MOD: begin
          rem     <= rem_next;
          shift   <= shift << MOD_BITS_PER_CYCLE;
          mod_cnt <= mod_cnt + 1'b1;
          if (mod_cnt == MOD_CNT_W'(MOD_CYCLES - 1)) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_RESP;
        end
        S_RESP: begin
          // hold the result until the output register is free
          if (!result_valid || result_ready) begin
            result_valid      <= 1'b1;
            result.outcome    <= res_from_mem ? rd_data : res_outcome;
            result.status     <= res_status;
            result.fill_level <= FILL_W'(fill_pointer);
            state             <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
      // a register write restarts the table
      if (restart) begin
        fill_pointer    <= '0;
        outcome_counter <= '0;
        table_ready     <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_pointer <= scale)
    else $error("fill pointer passed the table size");

  a_counter_bound: assert property (@(posedge clk) disable iff (rst)
    outcome_counter <= CNT_W'(MAX_OUTCOMES))
    else $error("outcome counter passed its limit");

  a_fill_progress: assert property (@(posedge clk) disable iff (rst)
    state == S_FILL |-> fill_pointer < fill_end)
    else $error("fill ran past its end");

  a_not_ready_zero: assert property (@(posedge clk) disable iff (rst)
    result_valid && result.status == ST_NOT_READY |-> result.outcome == '0)
    else $error("not-ready result carries an outcome");
`endif

endmodule

### rtl/core/discrete_sampler_lookup_table.sv
// ----------------------------------------------------------------------------
// discrete_sampler_lookup_table
// Table-lookup sampler for an arbitrary discrete distribution.
// ----------------------------------------------------------------------------
// Start and ignored items pass the front stage, the queue and the back end to the
// result register; a load or finish first writes its table entries in the fill
// state. A sample passes front and queue, the remainder unit (4 bits per cycle of
// the 32-bit word), one table read, then the result register.
// Throughput: one item at a time in the back end; the two-entry queue and the
// front stage keep accepting while a result waits. Reset clears control state
// only; the table is not cleared and needs no clearing pass.
module discrete_sampler_lookup_table import dsl_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_wen,
  input  logic [DIGITS_W-1:0] cfg_wdata,
  input  logic                item_valid,
  output logic                item_ready,
  input  item_t               item,
  output logic                result_valid,
  input  logic                result_ready,
  output result_t             result
);

  logic [DIGITS_W-1:0] decimal_digits;
  logic [SCALE_W-1:0]  scale;
  logic                cmd_valid;
  logic                cmd_ready;
  cmd_t                cmd;
  logic                q_valid;
  logic                q_ready;
  cmd_t                q_cmd;

  assign scale = scale_of(decimal_digits);

  always_ff @(posedge clk) begin
    if (rst) begin
      decimal_digits <= DIGITS_RESET;
    end else if (cfg_wen) begin
      decimal_digits <= cfg_wdata;
    end
  end

  dsl_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .item       (item),
    .scale      (scale),
    .cmd_valid  (cmd_valid),
    .cmd_ready  (cmd_ready),
    .cmd        (cmd)
  );

  dsl_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (cmd_valid),
    .push_ready (cmd_ready),
    .push_data  (cmd),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_data   (q_cmd)
  );

  dsl_back u_back (
    .clk          (clk),
    .rst          (rst),
    .restart      (cfg_wen),
    .scale        (scale),
    .cmd_valid    (q_valid),
    .cmd_ready    (q_ready),
    .cmd          (q_cmd),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
  );

endmodule
